// ===== sv/usl_pkg.sv =====
// usl_pkg: shared sizes, codes and transaction types of the unordered set list table
// no dependencies; compile first

package usl_pkg;

	// list storage
	localparam int DEPTH   = 64;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int KEY_W   = 32;

	// capacity register and result count
	localparam int CAP_W       = 7;
	localparam int COUNT_OUT_W = 7;
	localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	// operation codes
	localparam logic [1:0] KIND_INSERT  = 2'd0;
	localparam logic [1:0] KIND_DELETE  = 2'd1;
	localparam logic [1:0] KIND_REVERSE = 2'd2;

	// status codes
	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_PRESENT  = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	typedef struct packed {
		logic [1:0]              kind;
		logic signed [KEY_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]             status;
		logic [COUNT_OUT_W-1:0] count_after;
	} out_item_t;

	// one write and one read request toward the entry memory
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [KEY_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_SHIFT,
		S_REV_HI,
		S_REV_WHI,
		S_REV_WLO
	} state_t;

endpackage

// ===== sv/usl_ram.sv =====
// usl_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module usl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/usl_seq.sv =====
// usl_seq: operation sequencer, key count and result register of the set list
// depends on usl_pkg; drives the entry memory through a mem_req_t

module usl_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  usl_pkg::in_item_t            cmd,
	input  logic [usl_pkg::CAP_W-1:0]    cap,
	output usl_pkg::mem_req_t            mem,
	input  logic [usl_pkg::KEY_W-1:0]    rdata,
	output logic                         done,
	output usl_pkg::out_item_t           result
);

	import usl_pkg::*;

	state_t            state_q, state_d;
	logic [1:0]        op_q, op_d;
	logic [KEY_W-1:0]  key_q, key_d;
	logic [KEY_W-1:0]  tmp_q, tmp_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  ptr_q, ptr_d;
	logic [ADDR_W-1:0] lo_q, lo_d;
	logic [ADDR_W-1:0] hi_q, hi_d;
	logic              pend_s1, pend_d;
	logic [ADDR_W-1:0] idx_s1, idx_d;
	logic              done_q, done_d;
	logic [2:0]        status_d;
	out_item_t         result_q;
	logic              full;
	logic              match;
	logic              more;
	logic [CMP_W-1:0]  cnt_ext;
	logic [CMP_W-1:0]  cnt_d_ext;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// full when the count reaches the capacity or the storage depth
	assign cnt_ext = CMP_W'(cnt_q);
	assign full    = (cnt_ext >= CMP_W'(cap)) || (cnt_q >= CNT_W'(DEPTH));

	// compare stage of the search walk
	assign match = pend_s1 && (rdata == key_q);
	// issue pointer still inside the occupied entries
	assign more  = (ptr_q < cnt_q);

	// next state, memory requests and result
	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		key_d    = key_q;
		tmp_d    = tmp_q;
		cnt_d    = cnt_q;
		ptr_d    = ptr_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		pend_d   = 1'b0;
		idx_d    = idx_s1;
		done_d   = 1'b0;
		status_d = ST_DONE;
		mem      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d  = cmd.kind;
					key_d = cmd.value;
					ptr_d = '0;
					unique case (cmd.kind)
						KIND_INSERT: begin
							if (full) begin
								done_d   = 1'b1;
								status_d = ST_FULL;
							end else begin
								state_d = S_SRCH;
							end
						end
						KIND_DELETE: begin
							if (cnt_q == '0) begin
								done_d   = 1'b1;
								status_d = ST_EMPTY;
							end else begin
								state_d = S_SRCH;
							end
						end
						KIND_REVERSE: begin
							if (cnt_q < CNT_W'(2)) begin
								done_d = 1'b1;
							end else begin
								mem.re    = 1'b1;
								mem.raddr = '0;
								lo_d      = '0;
								hi_d      = ADDR_W'(cnt_q - CNT_W'(1));
								state_d   = S_REV_HI;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_SRCH: begin
				// one read issued and one entry compared each cycle
				if (more) begin
					mem.re    = 1'b1;
					mem.raddr = ptr_q[ADDR_W-1:0];
					ptr_d     = ptr_q + CNT_W'(1);
					pend_d    = 1'b1;
					idx_d     = ptr_q[ADDR_W-1:0];
				end
				if (match) begin
					pend_d = 1'b0;
					if (op_q == KIND_INSERT) begin
						done_d   = 1'b1;
						status_d = ST_PRESENT;
						state_d  = S_IDLE;
					end else begin
						ptr_d   = CNT_W'(idx_s1) + CNT_W'(1);
						state_d = S_SHIFT;
					end
				end else if (!pend_s1 && !more) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
					if (op_q == KIND_INSERT) begin
						mem.we    = 1'b1;
						mem.waddr = cnt_q[ADDR_W-1:0];
						mem.wdata = key_q;
						cnt_d     = cnt_q + CNT_W'(1);
					end else begin
						status_d = ST_NOTFOUND;
					end
				end
			end
			S_SHIFT: begin
				// read entry i+1, write it to i in the next cycle
				if (more) begin
					mem.re    = 1'b1;
					mem.raddr = ptr_q[ADDR_W-1:0];
					ptr_d     = ptr_q + CNT_W'(1);
					pend_d    = 1'b1;
					idx_d     = ptr_q[ADDR_W-1:0];
				end
				if (pend_s1) begin
					mem.we    = 1'b1;
					mem.waddr = idx_s1 - ADDR_W'(1);
					mem.wdata = rdata;
				end else if (!more) begin
					cnt_d   = cnt_q - CNT_W'(1);
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_REV_HI: begin
				tmp_d     = rdata;
				mem.re    = 1'b1;
				mem.raddr = hi_q;
				state_d   = S_REV_WHI;
			end
			S_REV_WHI: begin
				mem.we    = 1'b1;
				mem.waddr = hi_q;
				mem.wdata = tmp_q;
				tmp_d     = rdata;
				state_d   = S_REV_WLO;
			end
			S_REV_WLO: begin
				mem.we    = 1'b1;
				mem.waddr = lo_q;
				mem.wdata = tmp_q;
				lo_d      = lo_q + ADDR_W'(1);
				hi_d      = hi_q - ADDR_W'(1);
				// next pair still apart: fetch its low entry now
				if (({1'b0, lo_q} + (ADDR_W+1)'(2)) < {1'b0, hi_q}) begin
					mem.re    = 1'b1;
					mem.raddr = lo_q + ADDR_W'(1);
					state_d   = S_REV_HI;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign cnt_d_ext = CMP_W'(cnt_d);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_s1 <= pend_d;
			done_q  <= done_d;
		end
	end

	// operands, pointers and result payload
	always_ff @(posedge clk) begin
		op_q   <= op_d;
		key_q  <= key_d;
		tmp_q  <= tmp_d;
		ptr_q  <= ptr_d;
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		idx_s1 <= idx_d;
		if (done_d) begin
			result_q.status      <= status_d;
			result_q.count_after <= cnt_d_ext[COUNT_OUT_W-1:0];
		end
	end

	// a read and a write never meet at one entry
	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(mem.we && mem.re) |-> (mem.waddr != mem.raddr))
		else $error("entry read and written in the same cycle");

	// count stays within the storage
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("key count above depth");

	// an accepted transaction either finishes at once or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done_q))
		else $error("accepted transaction left no trace");

	// memory is only written while an operation is under way
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem.we |-> busy)
		else $error("memory write while idle");

endmodule

// ===== sv/unordered_set_list_table_top.sv =====
// unordered_set_list_table_top: set list of distinct keys with insert, delete, reverse
// depends on usl_pkg, usl_ram, usl_seq
//
// channel   signals                          transfer
// -------   -------------------------------  --------------------------------
// command   start, busy, cmd                 start high while busy low
// result    done, result                     done high for one cycle, no stall
// config    cfg_valid, cfg_ready, cfg_data   cfg_valid and cfg_ready high
//
// keys live in one DEPTH x 32 ram; a single read port sets the pace.
// insert: search walk over the stored keys, append if absent; full or kind three: done at once.
// delete: search up to the key, then one shift per later entry.
// reverse: swaps pairs from both ends inward, reading both entries, then writing each.
// reset clears the count and loads capacity 64; the ram needs no clearing.
// results cannot be stalled; the next command is taken in the cycle done shows.

module unordered_set_list_table_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  usl_pkg::in_item_t         cmd,
	output logic                      done,
	output usl_pkg::out_item_t        result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [usl_pkg::CAP_W-1:0] cfg_data
);

	import usl_pkg::*;

	logic [CAP_W-1:0] cap_q;
	mem_req_t         mem;
	logic [KEY_W-1:0] rdata;

	// capacity register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// entry storage
	usl_ram #(
		.WIDTH(KEY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem.we),
		.waddr(mem.waddr),
		.wdata(mem.wdata),
		.re   (mem.re),
		.raddr(mem.raddr),
		.rdata(rdata)
	);

	// operation sequencer
	usl_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.cap   (cap_q),
		.mem   (mem),
		.rdata (rdata),
		.done  (done),
		.result(result)
	);

endmodule
